// ===== rtl/core/bpc_pkg.sv =====
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types and constants for the button press classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package bpc_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned CfgIdxW = 2;

  // Machine states, as seen on the result port
  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_PRESSED  = 3'd1,
    ST_RELEASED = 3'd2,
    ST_LONG     = 3'd3,
    ST_LONGEND  = 3'd4
  } state_e;

  // Event codes, one per scan
  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_DOWN   = 3'd1,
    EV_SHORT  = 3'd2,
    EV_LSTART = 3'd3,
    EV_LSTOP  = 3'd4
  } event_e;

  // Configuration register indices
  typedef enum logic [CfgIdxW-1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_PRESS    = 2'd1,
    REG_LONG     = 2'd2,
    REG_ACTIVE   = 2'd3
  } reg_idx_e;

  localparam logic [CfgW-1:0] DebounceRst = 16'd25;
  localparam logic [CfgW-1:0] PressRst    = 16'd50;
  localparam logic [CfgW-1:0] LongRst     = 16'd800;
  localparam logic            ActiveRst   = 1'b0;

  typedef struct packed {
    logic [CfgW-1:0] debounce_ms;
    logic [CfgW-1:0] press_ms;
    logic [CfgW-1:0] long_press_ms;
    logic            active_level;
  } cfg_t;

  // One scan, as held in the input stage
  typedef struct packed {
    logic             pin_level;
    logic [TimeW-1:0] now_ms;
  } scan_t;

  // Outcome of one scan
  typedef struct packed {
    event_e event_code;
    state_e machine_state;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/bpc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// bpc_cfg_regs
// Configuration register file, write only.
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_cfg_regs (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [bpc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [bpc_pkg::CfgW-1:0]    cfg_wdata_i,
  output bpc_pkg::cfg_t                    cfg_o
);

  bpc_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (bpc_pkg::reg_idx_e'(cfg_idx_i))
        bpc_pkg::REG_DEBOUNCE: cfg_d.debounce_ms   = cfg_wdata_i;
        bpc_pkg::REG_PRESS:    cfg_d.press_ms      = cfg_wdata_i;
        bpc_pkg::REG_LONG:     cfg_d.long_press_ms = cfg_wdata_i;
        bpc_pkg::REG_ACTIVE:   cfg_d.active_level  = cfg_wdata_i[0];
        default:               cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms   <= bpc_pkg::DebounceRst;
      cfg_q.press_ms      <= bpc_pkg::PressRst;
      cfg_q.long_press_ms <= bpc_pkg::LongRst;
      cfg_q.active_level  <= bpc_pkg::ActiveRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/core/bpc_fsm.sv =====
// ----------------------------------------------------------------------------
// bpc_fsm
// Press state machine: state registers and the per-scan transition logic.
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_fsm (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   step_i,   // apply scan_i this cycle
  input  wire bpc_pkg::scan_t scan_i,
  input  wire bpc_pkg::cfg_t  cfg_i,
  output bpc_pkg::result_t res_o
);

  bpc_pkg::state_e cur_q, cur_d;
  bpc_pkg::state_e prev_q, prev_d;
  logic [bpc_pkg::TimeW-1:0] start_q, start_d;
  logic down_q, down_d;

  logic [bpc_pkg::TimeW-1:0] wait_ms;
  logic [bpc_pkg::TimeW-1:0] deb_ext, press_ext, long_ext;
  logic active, below_deb;
  bpc_pkg::event_e ev;

  assign wait_ms   = scan_i.now_ms - start_q;   // wraps modulo 2^32
  assign deb_ext   = {{(bpc_pkg::TimeW-bpc_pkg::CfgW){1'b0}}, cfg_i.debounce_ms};
  assign press_ext = {{(bpc_pkg::TimeW-bpc_pkg::CfgW){1'b0}}, cfg_i.press_ms};
  assign long_ext  = {{(bpc_pkg::TimeW-bpc_pkg::CfgW){1'b0}}, cfg_i.long_press_ms};
  assign active    = (scan_i.pin_level == cfg_i.active_level);
  assign below_deb = (wait_ms < deb_ext);

  always_comb begin
    cur_d   = cur_q;
    prev_d  = prev_q;
    start_d = start_q;
    down_d  = down_q;
    ev      = bpc_pkg::EV_NONE;
    unique case (cur_q)
      bpc_pkg::ST_IDLE: begin
        if (active) begin
          prev_d  = cur_q;
          cur_d   = bpc_pkg::ST_PRESSED;
          start_d = scan_i.now_ms;
        end
      end
      bpc_pkg::ST_PRESSED: begin
        priority if (!active && below_deb) begin
          // bounce back
          prev_d = cur_q;
          cur_d  = prev_q;
        end else if (active && (wait_ms > long_ext)) begin
          ev     = bpc_pkg::EV_LSTART;
          prev_d = cur_q;
          cur_d  = bpc_pkg::ST_LONG;
        end else begin
          if (!down_q) begin
            ev     = bpc_pkg::EV_DOWN;
            down_d = 1'b1;
          end
          if (!active) begin
            prev_d  = cur_q;
            cur_d   = bpc_pkg::ST_RELEASED;
            start_d = scan_i.now_ms;
          end
        end
      end
      bpc_pkg::ST_RELEASED: begin
        priority if (active && below_deb) begin
          prev_d = cur_q;
          cur_d  = prev_q;
        end else if (!active && (wait_ms > press_ext)) begin
          ev      = bpc_pkg::EV_SHORT;
          cur_d   = bpc_pkg::ST_IDLE;
          prev_d  = bpc_pkg::ST_IDLE;
          start_d = '0;
          down_d  = 1'b0;
        end
      end
      bpc_pkg::ST_LONG: begin
        if (!active) begin
          prev_d  = cur_q;
          cur_d   = bpc_pkg::ST_LONGEND;
          start_d = scan_i.now_ms;
        end
      end
      bpc_pkg::ST_LONGEND: begin
        priority if (active && below_deb) begin
          prev_d = cur_q;
          cur_d  = prev_q;
        end else if (!below_deb) begin
          ev      = bpc_pkg::EV_LSTOP;
          cur_d   = bpc_pkg::ST_IDLE;
          prev_d  = bpc_pkg::ST_IDLE;
          start_d = '0;
          down_d  = 1'b0;
        end
      end
      default: begin
        prev_d = cur_q;
        cur_d  = bpc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q   <= bpc_pkg::ST_IDLE;
      prev_q  <= bpc_pkg::ST_IDLE;
      start_q <= '0;
      down_q  <= 1'b0;
    end else if (step_i) begin
      cur_q   <= cur_d;
      prev_q  <= prev_d;
      start_q <= start_d;
      down_q  <= down_d;
    end
  end

  assign res_o.event_code    = ev;
  assign res_o.machine_state = cur_d;

endmodule

`default_nettype wire

// ===== rtl/core/button_press_classifier_unit.sv =====
// A scan transaction is registered in the scan stage, then its result in the result stage.
// Throughput: one scan per cycle while out_ready_i is high; the state update is
//   a single compare-and-select pass, so the scan register feeds it every cycle.
// Reset (rst_ni, async, active low): machine idle, start time zero, no press
//   reported, registers at debounce 25 ms, press 50 ms, long press 800 ms,
//   active level low; both pipeline stages empty.
// ----------------------------------------------------------------------------
// button_press_classifier_unit
// Debounced short/long press classifier: one event code per scan.
// ----------------------------------------------------------------------------
`default_nettype none

module button_press_classifier_unit (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // configuration writes
  input  wire logic                              cfg_we_i,
  input  wire logic [bpc_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  wire logic [bpc_pkg::CfgW-1:0]          cfg_wdata_i,
  // scan input
  input  wire logic                              in_valid_i,
  output      logic                              in_ready_o,
  input  wire logic                              pin_level_i,
  input  wire logic [bpc_pkg::TimeW-1:0]         now_ms_i,
  // result output
  output      logic                              out_valid_o,
  input  wire logic                              out_ready_i,
  output      logic [2:0]                        event_code_o,
  output      logic [2:0]                        machine_state_o
);

  bpc_pkg::cfg_t    cfg;
  bpc_pkg::scan_t   scan_q;
  bpc_pkg::result_t res, res_q;
  logic scan_vld_q, out_vld_q;
  logic advance;   // scan stage moves into the result stage (and the FSM steps)

  bpc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // The result stage can load whenever it is empty or being drained this
  // cycle; the scan stage, in turn, takes a new transaction whenever it is
  // empty or handing its scan on. Neither side waits for the other to idle.
  assign advance    = scan_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !scan_vld_q || advance;

  // Scan stage: the payload needs no reset, only the valid flag does.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      scan_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      scan_q.pin_level <= pin_level_i;
      scan_q.now_ms    <= now_ms_i;
    end
  end

  // The FSM state only moves when its scan is committed to the result
  // stage, so each scan sees exactly the state left by the one before.
  bpc_fsm u_fsm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .scan_i (scan_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // Result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (!out_vld_q || out_ready_i) begin
      out_vld_q <= scan_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign event_code_o    = res_q.event_code;
  assign machine_state_o = res_q.machine_state;

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: button press classifier testbench
// Drives scan transactions (pin level, millisecond time) into the classifier
// and predicts event code and machine state for each scan with its own
// copy of the debounce machine, checking every result transaction in order.
// ----------------------------------------------------------------------------

module tb;
  import bpc_pkg::*;

  // Run-length guard: far above the slowest legal run of this item count
  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned IdlePct    = 18;

  // --------------------------------------------------------------------------
  // Clock, reset and block ports
  // --------------------------------------------------------------------------
  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [1:0]  cfg_idx_i   = REG_DEBOUNCE;
  logic [15:0] cfg_wdata_i = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic        pin_level_i = 1'b0;
  logic [31:0] now_ms_i    = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  event_code_o;
  logic [2:0]  machine_state_o;

  // 12 ns period
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  button_press_classifier_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .pin_level_i     (pin_level_i),
    .now_ms_i        (now_ms_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .event_code_o    (event_code_o),
    .machine_state_o (machine_state_o)
  );

  // --------------------------------------------------------------------------
  // Predictor state: register copies and the debounce machine
  // --------------------------------------------------------------------------
  logic [15:0] deb_ms;
  logic [15:0] prs_ms;
  logic [15:0] lng_ms;
  logic        act_lvl;

  state_e      cur_st;
  state_e      prev_st;
  logic [31:0] t0_ms;       // time stamp of the last press/release edge
  bit          down_seen;   // press-down already reported for this press

  result_t     pending_outcomes[$];   // predicted results, oldest first

  int unsigned errors    = 0;
  int unsigned scans_in  = 0;
  int unsigned results   = 0;
  int unsigned cycles    = 0;
  bit          steady    = 1'b0;      // suppresses idling on both sides
  logic [31:0] t_ms;                  // scan time base for the gestures

  // Moving to a state keeps the old one for a possible bounce back
  function automatic void step_to(input state_e nxt);
    prev_st = cur_st;
    cur_st  = nxt;
  endfunction

  function automatic void clear_machine();
    cur_st    = ST_IDLE;
    prev_st   = ST_IDLE;
    t0_ms     = '0;
    down_seen = 1'b0;
  endfunction

  // One scan through the machine; returns event and resulting state.
  // Bounce back is step_to(prev_st): the argument is taken by value, so the
  // two states swap and the edge time stays put.
  function automatic result_t classify_scan(input logic lvl, input logic [31:0] now);
    logic [31:0] elapsed;
    logic        active;
    event_e      ev;
    result_t     res;
    elapsed = now - t0_ms;            // wraps modulo 2^32
    active  = (lvl == act_lvl);
    ev      = EV_NONE;
    case (cur_st)
      ST_IDLE: begin
        if (active) begin
          step_to(ST_PRESSED);
          t0_ms = now;
        end
      end
      ST_PRESSED: begin
        if (!active && elapsed < deb_ms) begin
          step_to(prev_st);
        end else if (active && elapsed > lng_ms) begin
          ev = EV_LSTART;
          step_to(ST_LONG);
        end else begin
          if (!down_seen) begin
            ev        = EV_DOWN;
            down_seen = 1'b1;
          end
          if (!active) begin
            step_to(ST_RELEASED);
            t0_ms = now;
          end
        end
      end
      ST_RELEASED: begin
        if (active && elapsed < deb_ms) begin
          step_to(prev_st);
        end else if (!active && elapsed > prs_ms) begin
          ev = EV_SHORT;
          clear_machine();
        end
      end
      ST_LONG: begin
        if (!active) begin
          step_to(ST_LONGEND);
          t0_ms = now;
        end
      end
      ST_LONGEND: begin
        if (active && elapsed < deb_ms) begin
          step_to(prev_st);
        end else if (elapsed >= deb_ms) begin
          ev = EV_LSTOP;
          clear_machine();
        end
      end
      default: step_to(ST_IDLE);
    endcase
    res.event_code    = ev;
    res.machine_state = cur_st;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Result side: random back-pressure and in-order checking
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    out_ready_i <= steady || ($urandom_range(99) >= IdlePct);
  end

  always @(posedge clk_i) begin : check_results
    result_t exp;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results++;
      if (pending_outcomes.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("MISMATCH result %0d: nothing outstanding (event %0d state %0d)",
                   results, event_code_o, machine_state_o);
      end else begin
        exp = pending_outcomes.pop_front();
        if (event_code_o !== exp.event_code || machine_state_o !== exp.machine_state) begin
          errors++;
          if (errors <= 10)
            $display("MISMATCH result %0d: event exp %0d got %0d, state exp %0d got %0d",
                     results, exp.event_code, event_code_o,
                     exp.machine_state, machine_state_o);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("tb: errors");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Scan side
  // --------------------------------------------------------------------------

  // Present one scan transaction and hold it until taken. Valid is only
  // dropped for an idle gap, so back-to-back scans keep it high throughout.
  task automatic send_scan(input logic lvl, input logic [31:0] now);
    while (!steady && $urandom_range(99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    pin_level_i <= lvl;
    now_ms_i    <= now;
    do @(posedge clk_i); while (!in_ready_o);
    pending_outcomes.push_back(classify_scan(lvl, now));
    scans_in++;
  endtask

  // Stop sending and let every outstanding result drain out
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // All four registers in consecutive cycles; the block must be idle.
  // Spare upper bits on the active-level write check the masking.
  task automatic program_regs(input logic [15:0] deb, input logic [15:0] prs,
                              input logic [15:0] lng, input logic act);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_DEBOUNCE;
    cfg_wdata_i <= deb;
    @(posedge clk_i);
    cfg_idx_i   <= REG_PRESS;
    cfg_wdata_i <= prs;
    @(posedge clk_i);
    cfg_idx_i   <= REG_LONG;
    cfg_wdata_i <= lng;
    @(posedge clk_i);
    cfg_idx_i   <= REG_ACTIVE;
    cfg_wdata_i <= {15'($urandom()), act};
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    deb_ms  = deb;
    prs_ms  = prs;
    lng_ms  = lng;
    act_lvl = act;
  endtask

  // n scans at one logical level, time advancing by 1..stepmax ms each
  task automatic hold_level(input bit pressed, input int unsigned n,
                            input int unsigned stepmax);
    for (int unsigned i = 0; i < n; i++) begin
      t_ms = t_ms + $urandom_range(stepmax, 1);
      send_scan(pressed ? act_lvl : ~act_lvl, t_ms);
    end
  endtask

  // Contact chatter: random levels at steps mostly inside the debounce window
  task automatic chatter(input int unsigned n);
    int unsigned stepmax;
    stepmax = deb_ms / 2 + 1;
    for (int unsigned i = 0; i < n; i++) begin
      t_ms = t_ms + $urandom_range(stepmax, 0);
      send_scan(1'($urandom_range(1, 0)), t_ms);
    end
  endtask

  // One user action, timed against the current register settings
  task automatic run_gesture();
    int unsigned kind;
    int unsigned deb_s;
    int unsigned prs_s;
    int unsigned lng_s;
    deb_s = deb_ms / 2 + 2;
    prs_s = prs_ms / 3 + 2;
    lng_s = lng_ms / 3 + 2;
    kind  = $urandom_range(9);
    case (kind)
      0, 1, 2, 3: begin
        // short press: held well under the long threshold, then released
        hold_level(1'b1, $urandom_range(4, 1), lng_ms / 8 + 1);
        if ($urandom_range(2) == 0) chatter($urandom_range(3, 1));
        hold_level(1'b0, $urandom_range(5, 2), prs_s);
      end
      4, 5, 6: begin
        // long press: held at steps up to about a third of the long threshold, then released
        hold_level(1'b1, $urandom_range(8, 3), lng_s);
        if ($urandom_range(1) == 0) chatter($urandom_range(3, 1));
        hold_level(1'b0, $urandom_range(4, 2), deb_s);
      end
      7: chatter($urandom_range(6, 2));
      8: begin
        // time jump: arbitrary stamp, arbitrary level
        t_ms = $urandom();
        send_scan(1'($urandom_range(1, 0)), t_ms);
      end
      default: hold_level(1'b0, $urandom_range(3, 1), prs_s);
    endcase
  endtask

  task automatic run_phase(input int unsigned n_items);
    int unsigned target;
    target = scans_in + n_items;
    while (scans_in < target) run_gesture();
    drain();
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset settings (25/50/800, active low): every event and state, bounce
  // back from each debounced state, and elapsed time across the wrap
  task automatic test_directed();
    send_scan(1'b1, 32'd0);            // released at time zero: stay idle
    send_scan(1'b1, 32'd100);
    send_scan(1'b0, 32'd1000);         // -> pressed
    send_scan(1'b0, 32'd1010);         // press down
    send_scan(1'b1, 32'd1015);         // bounce back to idle
    send_scan(1'b0, 32'd1020);         // pressed again, down already reported
    send_scan(1'b0, 32'd1030);
    send_scan(1'b1, 32'd1060);         // -> released
    send_scan(1'b0, 32'd1070);         // bounce back to pressed
    send_scan(1'b1, 32'd1080);         // inside debounce: back to released
    send_scan(1'b1, 32'd1111);         // short press
    send_scan(1'b0, 32'd2000);
    send_scan(1'b0, 32'd2001);         // press down
    send_scan(1'b0, 32'd2801);         // long start
    send_scan(1'b0, 32'd3000);
    send_scan(1'b1, 32'd3010);         // -> long press ending
    send_scan(1'b0, 32'd3020);         // bounce back to long press
    send_scan(1'b1, 32'd3030);
    send_scan(1'b1, 32'd3055);         // long stop, exactly at debounce
    send_scan(1'b1, 32'hFFFF_FFFF);
    send_scan(1'b0, 32'hFFFF_FFF0);    // press just before the wrap
    send_scan(1'b0, 32'hFFFF_FFF5);
    send_scan(1'b1, 32'h0000_0010);    // release after the wrap
    send_scan(1'b1, 32'h0000_0045);    // short press
    drain();
  endtask

  // Register extremes, both active levels, then back to reset values
  task automatic test_register_extremes();
    for (int k = 0; k < 6; k++) begin
      case (k)
        0: program_regs(16'd0, 16'd0, 16'd0, 1'b1);
        1: program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        2: program_regs(16'd0, 16'hFFFF, 16'd0, 1'b0);
        3: program_regs(16'hFFFF, 16'd0, 16'hFFFF, 1'b1);
        4: program_regs(16'd1, 16'd1, 16'd1, 1'b0);
        default: program_regs(DebounceRst, PressRst, LongRst, ActiveRst);
      endcase
      t_ms = (k % 2) ? 32'hFFFF_FFFF - $urandom_range(200000) : $urandom();
      run_phase(70);
    end
  endtask

  // Mostly realistic timings, now and then a full-range register
  task automatic random_regs();
    logic [15:0] deb;
    logic [15:0] prs;
    logic [15:0] lng;
    deb = ($urandom_range(5) == 0) ? 16'($urandom()) : 16'($urandom_range(40));
    prs = ($urandom_range(5) == 0) ? 16'($urandom()) : 16'($urandom_range(120));
    lng = ($urandom_range(5) == 0) ? 16'($urandom()) : 16'($urandom_range(1000));
    program_regs(deb, prs, lng, 1'($urandom_range(1, 0)));
  endtask

  task automatic test_random_gestures();
    for (int p = 0; p < 6; p++) begin
      random_regs();
      t_ms = $urandom();
      run_phase(100);
    end
  endtask

  // Full rate on both sides
  task automatic test_back_to_back();
    random_regs();
    steady = 1'b1;
    run_phase(250);
    steady = 1'b0;
  endtask

  // Arbitrary levels and stamps, interleaved with broken-off chatter
  task automatic test_scan_noise();
    int unsigned target;
    random_regs();
    target = scans_in + 150;
    while (scans_in < target) begin
      if ($urandom_range(1) == 0) begin
        t_ms = $urandom();
        send_scan(1'($urandom_range(1, 0)), t_ms);
      end else begin
        chatter($urandom_range(4, 1));
      end
    end
    drain();
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    deb_ms  = DebounceRst;
    prs_ms  = PressRst;
    lng_ms  = LongRst;
    act_lvl = ActiveRst;
    clear_machine();
    t_ms    = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_register_extremes();
    test_random_gestures();
    test_back_to_back();
    test_scan_noise();

    // nothing outstanding now; allow for the pipeline before judging
    repeat (8) @(posedge clk_i);
    if (errors == 0 && pending_outcomes.size() == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/bpc_pkg.sv
rtl/core/bpc_cfg_regs.sv
rtl/core/bpc_fsm.sv
rtl/core/button_press_classifier_unit.sv
tb/sv/tb.sv
